/* hdl/psc_pkg.sv */
// Shared types and codes for the postfix stack calculator.
package psc_pkg;

  typedef enum logic [1:0] {
    KIND_PUSH = 2'd0,
    KIND_OPER = 2'd1,
    KIND_POP  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2,
    ST_DIVZ  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_LOAD,
    S_CALC,
    S_POP,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] literal;
    logic [1:0]  op;
  } in_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [6:0]         depth;
    logic [1:0]         status;
  } out_t;

endpackage

/* hdl/psc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module psc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/psc_alu.sv */
// Shared 32-bit arithmetic unit: registered add/subtract, iterative multiply and divide.
module psc_alu (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  psc_pkg::op_e  op,
  input  logic [31:0]   lhs,
  input  logic [31:0]   rhs,
  output logic          done,
  output logic [31:0]   result
);
  import psc_pkg::*;

  localparam logic [5:0] STEP_LAST = 6'd31;
  localparam logic [5:0] STEP_FIX  = 6'd32;

  logic [31:0] rem;
  logic [31:0] q;
  logic [31:0] dsr;
  logic        neg;
  logic [5:0]  cnt;
  logic        busy;
  op_e         op_r;
  op_e         op_sel;
  logic [32:0] add_a;
  logic [32:0] add_b;
  logic        add_cin;
  logic [33:0] sum;
  logic        carry;

  function automatic logic [31:0] mag(input logic [31:0] v);
    return v[31] ? (32'd0 - v) : v;
  endfunction

  assign op_sel = start ? op : op_r;

  always_comb begin
    add_a   = {1'b0, lhs};
    add_b   = {1'b0, rhs};
    add_cin = 1'b0;
    case (op_sel)
      OP_ADD: begin
        add_a = {1'b0, lhs};
        add_b = {1'b0, rhs};
      end
      OP_SUB: begin
        add_a   = {1'b0, lhs};
        add_b   = ~{1'b0, rhs};
        add_cin = 1'b1;
      end
      OP_MUL: begin
        add_a = {1'b0, rem};
        add_b = {1'b0, q[0] ? dsr : 32'd0};
      end
      OP_DIV: begin
        if (cnt == STEP_FIX) begin
          add_a   = '0;
          add_b   = ~{1'b0, q};
          add_cin = 1'b1;
        end else begin
          add_a   = {rem, q[31]};
          add_b   = ~{1'b0, dsr};
          add_cin = 1'b1;
        end
      end
      default: begin
        add_a = {1'b0, lhs};
        add_b = {1'b0, rhs};
      end
    endcase
  end

  assign sum   = {1'b0, add_a} + {1'b0, add_b} + {33'd0, add_cin};
  assign carry = sum[33];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
      op_r <= OP_ADD;
    end else begin
      if (start) begin
        op_r <= op;
        cnt  <= '0;
        case (op)
          OP_ADD, OP_SUB: begin
            result <= sum[31:0];
            done   <= 1'b1;
          end
          OP_MUL: begin
            rem  <= '0;
            q    <= rhs;
            dsr  <= lhs;
            busy <= 1'b1;
            done <= 1'b0;
          end
          OP_DIV: begin
            rem  <= '0;
            q    <= mag(lhs);
            dsr  <= mag(rhs);
            neg  <= lhs[31] ^ rhs[31];
            busy <= 1'b1;
            done <= 1'b0;
          end
          default: begin
            result <= sum[31:0];
            done   <= 1'b1;
          end
        endcase
      end else if (busy) begin
        case (op_r)
          OP_MUL: begin
            rem <= sum[31:0];
            dsr <= {dsr[30:0], 1'b0};
            q   <= {1'b0, q[31:1]};
            cnt <= cnt + 6'd1;
            if (cnt == STEP_LAST) begin
              result <= sum[31:0];
              busy   <= 1'b0;
              done   <= 1'b1;
            end else begin
              done <= 1'b0;
            end
          end
          OP_DIV: begin
            if (cnt == STEP_FIX) begin
              result <= neg ? sum[31:0] : q;
              busy   <= 1'b0;
              done   <= 1'b1;
            end else begin
              rem  <= carry ? sum[31:0] : add_a[31:0];
              q    <= {q[30:0], carry};
              cnt  <= cnt + 6'd1;
              done <= 1'b0;
            end
          end
          default: begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        endcase
      end else begin
        done <= 1'b0;
      end
    end
  end

endmodule

/* hdl/postfix_stack_calculator.sv */
// Postfix stack calculator: token sequencer, stack RAM and shared arithmetic unit.
// Each token is captured in S_IDLE and executed in S_EXEC; operators then load and
// calculate (S_LOAD, S_CALC), pops with refill read the RAM (S_POP), then S_DONE.
// One token at a time; the next token is taken in the cycle after the result is
// registered. The iterative multiply/divide unit works one bit per cycle.
// Synchronous active-high reset empties the stack; stack RAM is not cleared.
module postfix_stack_calculator #(
  parameter int STACK_DEPTH = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          tok_valid,
  output logic          tok_stall,
  input  psc_pkg::in_t  tok,
  output logic          res_valid,
  input  logic          res_stall,
  output psc_pkg::out_t res
);
  import psc_pkg::*;

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);

  state_e        state;
  state_e        state_next;
  in_t           cur;
  logic [CW-1:0] count;
  logic [CW-1:0] cnt_m2;
  logic [31:0]   tos;
  logic [31:0]   pop_val;
  status_e       stat;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [31:0]   ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [31:0]   ram_rdata;

  logic          alu_start;
  logic          alu_done;
  logic [31:0]   alu_result;

  logic          full;
  logic          below_two;
  logic          empty;
  logic          out_load;

  assign cnt_m2    = count - CW'(2);
  assign full      = (count >= CW'(STACK_DEPTH));
  assign below_two = (count < CW'(2));
  assign empty     = (count == '0);
  assign ram_raddr = cnt_m2[AW-1:0];

  psc_ram #(
    .WIDTH(32),
    .DEPTH(STACK_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  psc_alu u_alu (
    .clk   (clk),
    .rst   (rst),
    .start (alu_start),
    .op    (op_e'(cur.op)),
    .lhs   (ram_rdata),
    .rhs   (tos),
    .done  (alu_done),
    .result(alu_result)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (tok_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        case (cur.kind)
          KIND_OPER: begin
            if (below_two || (cur.op == OP_DIV && tos == 32'd0)) state_next = S_DONE;
            else state_next = S_LOAD;
          end
          KIND_POP: begin
            if (below_two) state_next = S_DONE;
            else state_next = S_POP;
          end
          default: state_next = S_DONE;
        endcase
      end
      S_LOAD: state_next = S_CALC;
      S_CALC: begin
        if (alu_done) state_next = S_DONE;
      end
      S_POP: state_next = S_DONE;
      S_DONE: begin
        if (out_load) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    tok_stall = 1'b1;
    ram_we    = 1'b0;
    ram_waddr = cnt_m2[AW-1:0];
    ram_wdata = alu_result;
    alu_start = 1'b0;
    out_load  = 1'b0;
    case (state)
      S_IDLE: tok_stall = 1'b0;
      S_EXEC: begin
        if (cur.kind == KIND_PUSH && !full) begin
          ram_we    = 1'b1;
          ram_waddr = count[AW-1:0];
          ram_wdata = {16'd0, cur.literal};
        end
      end
      S_LOAD: alu_start = 1'b1;
      S_CALC: ram_we = alu_done;
      S_DONE: out_load = !res_valid || !res_stall;
      default: tok_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) res_valid <= 1'b1;
      else if (res_valid && !res_stall) res_valid <= 1'b0;
      case (state)
        S_EXEC: begin
          case (cur.kind)
            KIND_PUSH: begin
              if (!full) count <= count + CW'(1);
            end
            KIND_POP: begin
              if (!empty) count <= count - CW'(1);
            end
            default: ;
          endcase
        end
        S_CALC: begin
          if (alu_done) count <= count - CW'(1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (tok_valid) cur <= tok;
      end
      S_EXEC: begin
        case (cur.kind)
          KIND_PUSH: begin
            if (full) stat <= ST_OVER;
            else begin
              stat <= ST_OK;
              tos  <= {16'd0, cur.literal};
            end
          end
          KIND_OPER: begin
            if (below_two) stat <= ST_UNDER;
            else if (cur.op == OP_DIV && tos == 32'd0) stat <= ST_DIVZ;
            else stat <= ST_OK;
          end
          KIND_POP: begin
            if (empty) stat <= ST_UNDER;
            else begin
              stat    <= ST_OK;
              pop_val <= tos;
            end
          end
          default: stat <= ST_OK;
        endcase
      end
      S_CALC: begin
        if (alu_done) tos <= alu_result;
      end
      S_POP: tos <= ram_rdata;
      S_DONE: begin
        if (out_load) begin
          res.depth  <= 7'(count);
          res.status <= stat;
          if (cur.kind == KIND_POP && stat == ST_OK) res.value <= pop_val;
          else res.value <= empty ? 32'sd0 : tos;
        end
      end
      default: ;
    endcase
  end

endmodule
